// ===== rtl/core/sitda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for signed int to decimal ascii
// state encoding, character codes and the bcd correction step
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSign,
    StSkip,
    StEmit
  } state_e;

  // add 3 to every bcd digit that is 5 or more, ahead of the shift
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
    logic [BcdW-1:0] res;
    res = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal ascii text
// sequence: the sign character (if negative) follows the 32-step bit-serial double dabble,
//   then one cycle per digit place, skipped or sent; a new value is taken only when idle
// reset: asynchronous, active low; returns to idle, no character in flight
// the receiver cannot stall: each character beat shows for one cycle only
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [sitda_pkg::ValueW-1:0] value_i,
  output logic                             char_valid_o,
  output logic        [7:0]                text_char_o,
  output logic                             last_char_o
);

  // control state
  sitda_pkg::state_e state_q, state_d;
  logic [sitda_pkg::BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [sitda_pkg::DigCntW-1:0] dig_cnt_q, dig_cnt_d;

  // datapath: magnitude shift register feeding the bcd shift register
  logic [sitda_pkg::ValueW-1:0] mag_q, mag_d;
  logic [sitda_pkg::BcdW-1:0]   bcd_q, bcd_d;
  logic                         neg_q, neg_d;

  // bcd register after the add-3 correction, ahead of the shift
  logic [sitda_pkg::BcdW-1:0]   bcd_adj;

  // most significant remaining digit place
  logic [3:0] top_digit;
  logic       top_zero;
  logic       last_place;

  assign bcd_adj    = sitda_pkg::bcd_adjust(bcd_q);
  assign top_digit  = bcd_q[sitda_pkg::BcdW-1 -: 4];
  assign top_zero   = (top_digit == 4'd0);
  assign last_place = (dig_cnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sitda_pkg::StIdle: begin
        if (start_i) begin
          state_d = sitda_pkg::StConv;
        end
      end
      sitda_pkg::StConv: begin
        if (bit_cnt_q == '0) begin
          state_d = neg_q ? sitda_pkg::StSign : sitda_pkg::StSkip;
        end
      end
      sitda_pkg::StSign: begin
        state_d = sitda_pkg::StSkip;
      end
      sitda_pkg::StSkip: begin
        // leave skipping once the first nonzero digit (or the units) goes out
        if (!top_zero || last_place) begin
          state_d = last_place ? sitda_pkg::StIdle : sitda_pkg::StEmit;
        end
      end
      sitda_pkg::StEmit: begin
        if (last_place) begin
          state_d = sitda_pkg::StIdle;
        end
      end
      default: begin
        state_d = sitda_pkg::StIdle;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy_o       = (state_q != sitda_pkg::StIdle);
    char_valid_o = 1'b0;
    text_char_o  = sitda_pkg::AsciiZero | {4'd0, top_digit};
    last_char_o  = 1'b0;
    case (state_q)
      sitda_pkg::StSign: begin
        char_valid_o = 1'b1;
        text_char_o  = sitda_pkg::AsciiMinus;
      end
      sitda_pkg::StSkip: begin
        char_valid_o = !top_zero || last_place;
        last_char_o  = last_place;
      end
      sitda_pkg::StEmit: begin
        char_valid_o = 1'b1;
        last_char_o  = last_place;
      end
      default: begin
        char_valid_o = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    case (state_q)
      sitda_pkg::StIdle: begin
        if (start_i) begin
          // magnitude as unsigned, so the most negative value maps to 2^31
          neg_d     = value_i[sitda_pkg::ValueW-1];
          mag_d     = value_i[sitda_pkg::ValueW-1] ? (~value_i + 1'b1) : value_i;
          bcd_d     = '0;
          bit_cnt_d = sitda_pkg::BitCntW'(sitda_pkg::ValueW - 1);
        end
      end
      sitda_pkg::StConv: begin
        // one magnitude bit per cycle into the corrected bcd register
        bcd_d     = {bcd_adj[sitda_pkg::BcdW-2:0], mag_q[sitda_pkg::ValueW-1]};
        mag_d     = {mag_q[sitda_pkg::ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        dig_cnt_d = sitda_pkg::DigCntW'(sitda_pkg::NumDigits - 1);
      end
      sitda_pkg::StSkip, sitda_pkg::StEmit: begin
        // one digit place per cycle, whether skipped or sent
        bcd_d = {bcd_q[sitda_pkg::BcdW-5:0], 4'd0};
        if (!last_place) begin
          dig_cnt_d = dig_cnt_q - 1'b1;
        end
      end
      default: begin
        bcd_d = bcd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sitda_pkg::StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

endmodule
